FILE: src/tlmpm_pkg.sv
// Shared types, constants and control structs for the threshold local-max peak merger.
package tlmpm_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int THR_W           = 16;
    localparam int MW_W            = 8;
    localparam int PEAK_W          = 32;
    localparam int CNT_W           = 10;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;

    localparam int HALF_WINDOW_DEF = 3;
    localparam int INDEX_W_DEF     = 32;

    localparam logic [CNT_W-1:0]     COUNT_MAX     = 10'd1023;
    localparam logic [THR_W-1:0]     THR_RESET     = 16'd32768;
    localparam logic [MW_W-1:0]      MW_RESET      = 8'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE     = 4'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                final_sample;
    } in_item_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_frame;
        logic              is_peak;
        logic              last_of_run;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic open;
        logic add;
        logic div_start;
        logic emit_cluster;
        logic emit_marker;
        logic last;
        logic clear;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic peak_hit;
        logic cluster_open;
        logic add_ok;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/tlmpm_div.sv
// Restoring bit-serial divider for the cluster mean, one quotient bit per cycle.
module tlmpm_div #(
    parameter int IDX_W = tlmpm_pkg::INDEX_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [IDX_W+tlmpm_pkg::CNT_W:0] numer,
    input  logic [tlmpm_pkg::CNT_W:0]     denom,
    output logic                          busy,
    output logic [IDX_W-1:0]              quot
);
    import tlmpm_pkg::*;

    localparam int DEN_W  = CNT_W + 1;
    localparam int NUM_W  = IDX_W + DEN_W;
    localparam int ITER_W = $clog2(IDX_W + 1);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [IDX_W-1:0]  q_reg, q_next;
    logic [ITER_W-1:0] cnt_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // The quotient always fits in IDX_W bits, so the upper numerator bits
    // start out as a partial remainder that is already below the divisor.
    always_comb begin
        trial    = {rem_reg, q_reg[IDX_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_next   = {q_reg[IDX_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= ITER_W'(IDX_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= numer[NUM_W-1:IDX_W];
            q_reg   <= numer[IDX_W-1:0];
            den_reg <= denom;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

FILE: src/tlmpm_datapath.sv
// Datapath: sample window, peak test, cluster accumulators, mean divider and result register.
module tlmpm_datapath #(
    parameter int HALF_WINDOW = tlmpm_pkg::HALF_WINDOW_DEF,
    parameter int IDX_W       = tlmpm_pkg::INDEX_W_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tlmpm_pkg::in_item_t                  s_data,
    input  logic                                 cfg_valid,
    input  logic [tlmpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlmpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  tlmpm_pkg::dp_cmd_t                   cmd,
    output tlmpm_pkg::dp_status_t                status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tlmpm_pkg::out_item_t                 m_data
);
    import tlmpm_pkg::*;

    localparam int WIN_DEPTH = 2 * HALF_WINDOW + 1;
    localparam int SUM_W     = IDX_W + CNT_W;
    localparam int DEN_W     = CNT_W + 1;
    localparam int NUM_W     = IDX_W + DEN_W;
    localparam int MWC_W     = MW_W + CNT_W;

    logic [THR_W-1:0]    thr_reg;
    logic [MW_W-1:0]     mw_reg;

    logic [SAMPLE_W-1:0] win_reg [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] val_reg;
    logic [WIN_DEPTH-1:0] greater;

    logic [IDX_W-1:0]    frames_seen_reg;
    logic [IDX_W-1:0]    cand_reg;
    logic [IDX_W-1:0]    base_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [IDX_W-1:0]    off_reg;
    logic [SUM_W-1:0]    lhs_reg, lhs_next;
    logic [MWC_W-1:0]    mwc_reg, mwc_next;
    logic [SUM_W-1:0]    excess;
    logic                join_ok;

    logic [NUM_W-1:0]    numer;
    logic [DEN_W-1:0]    denom;
    logic                div_busy;
    logic [IDX_W-1:0]    quot;
    logic [IDX_W-1:0]    mean_idx;
    logic [IDX_W+PEAK_W-1:0] frame_ext;

    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic                out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            mw_reg  <= MW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_MERGE:     mw_reg  <= cfg_data[MW_W-1:0];
                default:       ;
            endcase
        end
    end

    // The window shifts by age: tap 0 holds the newest frame. On the final
    // request empty taps are shifted in so that the tail frames pass the center.
    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.shift) begin
            win_reg[0] <= s_data.sample_value;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (cmd.clear) begin
            val_reg <= '0;
        end else if (cmd.load) begin
            val_reg <= {val_reg[WIN_DEPTH-2:0], 1'b1};
        end else if (cmd.shift) begin
            val_reg <= {val_reg[WIN_DEPTH-2:0], 1'b0};
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            greater[i] = val_reg[i] && (win_reg[i] > win_reg[HALF_WINDOW]);
        end
    end

    // Frame counter and index of the frame at the window center.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_seen_reg <= '0;
        end else if (cmd.clear) begin
            frames_seen_reg <= '0;
        end else if (cmd.load) begin
            frames_seen_reg <= frames_seen_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg <= frames_seen_reg - IDX_W'(HALF_WINDOW);
        end else if (cmd.shift) begin
            cand_reg <= cand_reg + 1'b1;
        end
    end

    // Cluster accumulators; the count alone tells whether a cluster is open.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.open) begin
            count_reg <= CNT_W'(1);
        end else if (cmd.add) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.open) begin
            base_reg <= cand_reg;
            sum_reg  <= '0;
        end else if (cmd.add) begin
            sum_reg  <= sum_reg + SUM_W'(off_reg);
        end
    end

    // Join test pipeline: offset, then products, then compare.
    assign lhs_next = off_reg * count_reg;
    assign mwc_next = mw_reg * count_reg;

    always_ff @(posedge aclk) begin
        off_reg <= cand_reg - base_reg;
        lhs_reg <= lhs_next;
        mwc_reg <= mwc_next;
    end

    // A peak whose scaled offset lies below the sum only arises after an
    // index wrap and then always joins.
    assign excess  = lhs_reg - sum_reg;
    assign join_ok = (lhs_reg < sum_reg) || (excess <= SUM_W'(mwc_reg));

    // Rounded mean offset: (2*sum + count) / (2*count).
    assign numer = {sum_reg, 1'b0} + NUM_W'(count_reg);
    assign denom = {count_reg, 1'b0};

    tlmpm_div #(
        .IDX_W (IDX_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (numer),
        .denom   (denom),
        .busy    (div_busy),
        .quot    (quot)
    );

    assign mean_idx  = base_reg + quot;
    assign frame_ext = {{PEAK_W{1'b0}}, mean_idx};

    // Output register.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_cluster || cmd.emit_marker) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_cluster) begin
            m_data_reg.peak_frame  <= frame_ext[PEAK_W-1:0];
            m_data_reg.is_peak     <= 1'b1;
            m_data_reg.last_of_run <= cmd.last;
        end else if (cmd.emit_marker) begin
            m_data_reg.peak_frame  <= '0;
            m_data_reg.is_peak     <= 1'b0;
            m_data_reg.last_of_run <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status.peak_hit     = val_reg[HALF_WINDOW]
                              && (win_reg[HALF_WINDOW] > thr_reg)
                              && !(|greater);
        status.cluster_open = (count_reg != '0);
        status.add_ok       = join_ok && (count_reg != COUNT_MAX);
        status.div_busy     = div_busy;
        status.out_free     = out_free;
    end

endmodule

FILE: src/tlmpm_ctrl.sv
// Controller state machine sequencing judging, merging, division and result output.
module tlmpm_ctrl #(
    parameter int HALF_WINDOW = tlmpm_pkg::HALF_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  final_sample,
    output logic                  s_ready,
    input  tlmpm_pkg::dp_status_t status,
    output tlmpm_pkg::dp_cmd_t    cmd
);
    import tlmpm_pkg::*;

    localparam int STEP_W = $clog2(HALF_WINDOW + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_JUDGE = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_JOIN  = 8'b0000_1000,
        ST_NEXT  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_MARK  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic              fin_reg, fin_next;
    logic              flush_reg, flush_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            flush_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            flush_reg <= flush_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        flush_next = flush_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    fin_next   = final_sample;
                    flush_next = 1'b0;
                    step_next  = '0;
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (status.peak_hit && status.cluster_open) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.open   = status.peak_hit;
                    state_next = ST_NEXT;
                end
            end
            ST_MUL: begin
                state_next = ST_JOIN;
            end
            ST_JOIN: begin
                if (status.add_ok) begin
                    cmd.add    = 1'b1;
                    state_next = ST_NEXT;
                end else begin
                    cmd.div_start = 1'b1;
                    flush_next    = 1'b0;
                    state_next    = ST_DIV;
                end
            end
            ST_NEXT: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (step_reg == STEP_W'(HALF_WINDOW)) begin
                    if (status.cluster_open) begin
                        cmd.div_start = 1'b1;
                        flush_next    = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_MARK;
                    end
                end else begin
                    cmd.shift  = 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_JUDGE;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_cluster = 1'b1;
                    cmd.last         = !fin_reg;
                    if (flush_reg) begin
                        state_next = ST_MARK;
                    end else begin
                        // The peak that closed the cluster opens the next one.
                        cmd.open   = 1'b1;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_MARK: begin
                if (status.out_free) begin
                    cmd.emit_marker = 1'b1;
                    cmd.clear       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/threshold_local_max_peak_merger.sv
// A request yields a result only when a peak closes a cluster or a final request ends the stream.
// A peak that meets an open cluster goes through the join test and either joins it or closes it;
// closing runs the bit-serial mean divider and then emits the result. A final request judges
// HALF_WINDOW + 1 frames and flushes. One request is in work at a time.
// A registered result waits for m_ready while the next request is taken in.
// Reset (aresetn low, synchronous) empties the window and cluster and restores register defaults.
module threshold_local_max_peak_merger #(
    parameter int HALF_WINDOW = tlmpm_pkg::HALF_WINDOW_DEF,
    parameter int INDEX_WIDTH = tlmpm_pkg::INDEX_W_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tlmpm_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tlmpm_pkg::out_item_t             m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlmpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlmpm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlmpm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tlmpm_ctrl #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .final_sample (s_data.final_sample),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    tlmpm_datapath #(
        .HALF_WINDOW (HALF_WINDOW),
        .IDX_W       (INDEX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: tb/sv/threshold_local_max_peak_merger_tb.sv
// Self-checking testbench for the threshold local-max peak merger.
`timescale 1ns / 1ps

module threshold_local_max_peak_merger_tb;
    import tlmpm_pkg::*;

    localparam int HALF  = HALF_WINDOW_DEF;
    localparam int DEPTH = 2 * HALF + 1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    threshold_local_max_peak_merger u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Idling mix for both sides, in percent of cycles.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned error_count   = 0;
    int unsigned frames_sent   = 0;
    int unsigned streams_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned clusters_made = 0;
    int unsigned reg_writes    = 0;

    // Predictor state: its own copy of the window, cluster and registers.
    logic [15:0]     win_mem [DEPTH];
    int unsigned     win_ptr;
    int unsigned     win_cnt;
    logic [31:0]     next_frame;
    logic [31:0]     clu_base;
    logic [63:0]     clu_sum;
    logic [63:0]     clu_count;
    logic [THR_W-1:0] thr_reg;
    logic [MW_W-1:0]  merge_reg;

    out_item_t frame_reports[$];
    out_item_t peak_reports_due[$];

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (peak_reports_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual frame %0d peak %0b last %0b",
                         $time, m_data.peak_frame, m_data.is_peak, m_data.last_of_run);
                error_count++;
            end else begin
                want = peak_reports_due.pop_front();
                results_seen++;
                if (m_data.peak_frame !== want.peak_frame) begin
                    $display("%0t ns: peak_frame mismatch, expected %0d, actual %0d",
                             $time, want.peak_frame, m_data.peak_frame);
                    error_count++;
                end
                if (m_data.is_peak !== want.is_peak) begin
                    $display("%0t ns: is_peak mismatch, expected %0b, actual %0b",
                             $time, want.is_peak, m_data.is_peak);
                    error_count++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $display("%0t ns: last_of_run mismatch, expected %0b, actual %0b",
                             $time, want.last_of_run, m_data.last_of_run);
                    error_count++;
                end
            end
        end
    end

    task automatic clear_stream();
        foreach (win_mem[i]) win_mem[i] = '0;
        win_ptr    = 0;
        win_cnt    = 0;
        next_frame = '0;
        clu_base   = '0;
        clu_sum    = '0;
        clu_count  = '0;
    endtask

    // Age 0 is the newest frame in the window.
    function automatic logic [15:0] window_at(int unsigned age);
        return win_mem[(win_ptr + DEPTH - 1 - (age % DEPTH)) % DEPTH];
    endfunction

    task automatic report_cluster();
        logic [63:0] mean_off;
        out_item_t   r;
        // Mean rounded half up, taken exactly from sum and count.
        mean_off      = (2 * clu_sum + clu_count) / (2 * clu_count);
        r.peak_frame  = clu_base + mean_off[31:0];
        r.is_peak     = 1'b1;
        r.last_of_run = 1'b0;
        frame_reports = {frame_reports, r};
        clusters_made++;
    endtask

    task automatic merge_peak(logic [31:0] frame);
        logic [31:0] off;
        logic [63:0] lhs;
        logic        join_ok;
        if (clu_count != 0) begin
            off = frame - clu_base;
            lhs = 64'(off) * clu_count;
            // A peak that lies below the mean always joins.
            if (lhs < clu_sum) join_ok = 1'b1;
            else join_ok = (lhs - clu_sum) <= 64'(merge_reg) * clu_count;
            if (join_ok && clu_count < 64'(COUNT_MAX)) begin
                clu_sum   = clu_sum + 64'(off);
                clu_count = clu_count + 1;
                return;
            end
            report_cluster();
        end
        clu_base  = frame;
        clu_sum   = '0;
        clu_count = 1;
    endtask

    task automatic judge_frame(int unsigned age, logic [31:0] newest);
        logic [15:0] v;
        int unsigned lo;
        int unsigned hi;
        v  = window_at(age);
        lo = (age > HALF) ? age - HALF : 0;
        hi = age + HALF;
        if (hi > win_cnt - 1) hi = win_cnt - 1;
        if (v <= thr_reg) return;
        for (int unsigned a = lo; a <= hi; a++) begin
            if (window_at(a) > v) return;
        end
        merge_peak(newest - 32'(age));
    endtask

    task automatic predict_frame(in_item_t item);
        logic [31:0] n;
        int          top;
        out_item_t   r;
        frame_reports.delete();
        n = next_frame;
        win_mem[win_ptr] = item.sample_value;
        win_ptr = (win_ptr + 1) % DEPTH;
        if (win_cnt < DEPTH) win_cnt++;
        next_frame = n + 1;
        if (!item.final_sample) begin
            if (win_cnt > HALF) judge_frame(HALF, n);
        end else begin
            // The tail is judged oldest first, clipped to what the window holds.
            top = (win_cnt - 1 < HALF) ? win_cnt - 1 : HALF;
            for (int a = top; a >= 0; a--) judge_frame(a, n);
            if (clu_count != 0) report_cluster();
            r = '0;
            frame_reports = {frame_reports, r};
            clear_stream();
        end
        for (int i = 0; i < frame_reports.size(); i++) begin
            r = frame_reports[i];
            r.last_of_run = (i == frame_reports.size() - 1);
            peak_reports_due = {peak_reports_due, r};
        end
    endtask

    task automatic send_frame(logic [15:0] value, logic fin);
        in_item_t item;
        item.sample_value = value;
        item.final_sample = fin;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_frame(item);
        frames_sent++;
    endtask

    task automatic send_stream(input logic [15:0] frames[$]);
        for (int i = 0; i < frames.size(); i++) send_frame(frames[i], i == frames.size() - 1);
        streams_sent++;
    endtask

    // Holds off the sender until every awaited result has arrived and the block has settled.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (peak_reports_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_THRESHOLD) thr_reg = data[THR_W-1:0];
        else if (index == CFG_MERGE) merge_reg = data[MW_W-1:0];
        reg_writes++;
        @(posedge aclk);
    endtask

    // Mix of full-range values, small values, values around the threshold, extremes and plateaus.
    function automatic logic [15:0] next_activation(logic [15:0] prev);
        int t;
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom_range(65535));
            4, 5: begin
                t = int'(thr_reg) + int'($urandom_range(4)) - 2;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                return 16'(t);
            end
            6:       return 16'd0;
            7:       return 16'hFFFF;
            8:       return prev;
            default: return 16'($urandom_range(2000));
        endcase
    endfunction

    task automatic test_single_and_short_streams();
        send_stream('{16'd65535});
        send_stream('{16'd0});
        send_stream('{16'd32768, 16'd32769, 16'd100});
    endtask

    task automatic test_plateau_and_merging();
        send_stream('{16'd40000, 16'd40000, 16'd10, 16'd10, 16'd60000,
                      16'd10, 16'd60000, 16'd10, 16'd10});
    endtask

    task automatic test_threshold_extremes();
        wait_until_drained();
        write_register(CFG_THRESHOLD, 16'd0);
        send_stream('{16'd0, 16'd1});
        wait_until_drained();
        write_register(CFG_THRESHOLD, 16'hFFFF);
        send_stream('{16'hFFFF});
    endtask

    task automatic test_merge_width_extremes();
        wait_until_drained();
        write_register(CFG_THRESHOLD, 16'd1000);
        write_register(CFG_MERGE, 16'd0);
        send_stream('{16'd5000, 16'd5000, 16'd5000});
        wait_until_drained();
        write_register(CFG_MERGE, 16'h00FF);
        send_stream('{16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5000});
    endtask

    task automatic test_random_streams(int unsigned gap_pct, int unsigned stall_pct,
                                       int unsigned n_frames);
        int unsigned sent;
        int unsigned len;
        logic [15:0] v;
        logic [15:0] thr_val;
        logic [7:0]  mw_val;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_frames) begin
            wait_until_drained();
            case ($urandom_range(5))
                0:       thr_val = 16'd0;
                1:       thr_val = 16'hFFFF;
                default: thr_val = 16'($urandom_range(16384, 49152));
            endcase
            case ($urandom_range(5))
                0:       mw_val = 8'd0;
                1:       mw_val = 8'd255;
                default: mw_val = 8'($urandom_range(8));
            endcase
            write_register(CFG_THRESHOLD, thr_val);
            // Upper data bits are outside the merge width field and must be dropped.
            write_register(CFG_MERGE, {8'($urandom_range(255)), mw_val});
            repeat ($urandom_range(1, 3)) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
                v = '0;
                for (int unsigned i = 0; i < len; i++) begin
                    v = next_activation(v);
                    send_frame(v, i == len - 1);
                    if ($urandom_range(29) == 0) wait_until_drained();
                end
                sent += len;
                streams_sent++;
            end
        end
    endtask

    initial begin
        thr_reg   = THR_RESET;
        merge_reg = MW_RESET;
        clear_stream();
        send_gap_pct   = 16;
        recv_stall_pct = 71;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_and_short_streams();
        test_plateau_and_merging();
        test_threshold_extremes();
        test_merge_width_extremes();
        test_random_streams(16, 71, 35);
        test_random_streams(71, 16, 35);
        test_random_streams(0, 0, 35);

        wait_until_drained();
        $display("Run covered %0d frames in %0d streams, %0d register writes.",
                 frames_sent, streams_sent, reg_writes);
        $display("Checked %0d results, %0d of them merged peaks, under three idling mixes.",
                 results_seen, clusters_made);
        if (error_count == 0) begin
            $display("threshold_local_max_peak_merger verification clean");
        end else begin
            $display("threshold_local_max_peak_merger verification failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Timeout with %0d results still awaited.", peak_reports_due.size());
        $display("threshold_local_max_peak_merger verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/tlmpm_pkg.sv
src/tlmpm_div.sv
src/tlmpm_datapath.sv
src/tlmpm_ctrl.sv
src/threshold_local_max_peak_merger.sv
tb/sv/threshold_local_max_peak_merger_tb.sv
